### rtl/hsvc_pkg.sv
package hsvc_pkg;

   localparam int HueWidth   = 9;
   localparam int ChanWidth  = 8;
   localparam int RemWidth   = 6;
   localparam int KWidth     = 14;
   localparam int NumWidth   = 22;
   localparam int RecipWidth = 23;
   localparam int RecipShift = 36;
   localparam int ProdWidth  = NumWidth + RecipWidth;

   localparam int FullScaleDen = 15300;

   localparam logic [HueWidth-1:0]  HueWrap    = 9'd360;
   localparam logic [RemWidth-1:0]  SectorSpan = 6'd60;
   localparam logic [KWidth-1:0]    KFull      = 14'd15300;
   localparam logic [NumWidth-1:0]  RoundBias  = 22'd7650;
   localparam logic [ChanWidth-1:0] GreyLimit  = 8'd2;

   localparam longint unsigned RecipFull =
      ((64'd1 << RecipShift) + 64'(FullScaleDen) - 64'd1) / 64'(FullScaleDen);
   localparam logic [RecipWidth-1:0] RecipLevel = RecipWidth'(RecipFull);

   localparam logic [2:0] SectorRedYellow    = 3'd0;
   localparam logic [2:0] SectorYellowGreen  = 3'd1;
   localparam logic [2:0] SectorGreenCyan    = 3'd2;
   localparam logic [2:0] SectorCyanBlue     = 3'd3;
   localparam logic [2:0] SectorBlueMagenta  = 3'd4;
   localparam logic [2:0] SectorMagentaRed   = 3'd5;

endpackage

### rtl/hsvc_req_if.sv
interface hsvc_req_if
   import hsvc_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic [HueWidth-1:0]  hue_deg;
   logic [ChanWidth-1:0] sat;
   logic [ChanWidth-1:0] val;

   modport source (output valid, output hue_deg, output sat, output val, input ready);
   modport sink (input valid, input hue_deg, input sat, input val, output ready);
endinterface

### rtl/hsvc_rsp_if.sv
interface hsvc_rsp_if
   import hsvc_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic [ChanWidth-1:0] red;
   logic [ChanWidth-1:0] green;
   logic [ChanWidth-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

### rtl/hsvc_level.sv
module hsvc_level
   import hsvc_pkg::*;
(
   input  logic                 clock,
   input  logic                 enable,
   input  logic [ChanWidth-1:0] sat,
   input  logic [ChanWidth-1:0] val,
   input  logic [RemWidth-1:0]  mul,
   output logic [ChanWidth-1:0] level
);

   logic [KWidth-1:0]    k_ff;
   logic [KWidth-1:0]    k_in;
   logic [ChanWidth-1:0] val_ff;
   logic [NumWidth-1:0]  num_ff;
   logic [NumWidth-1:0]  num_in;
   logic [ProdWidth-1:0] prod;
   logic [ChanWidth-1:0] level_ff;
   logic [ChanWidth-1:0] level_in;

   // Each level is round(val * k / 15300) with k = 15300 - sat * mul; the
   // division is an exact multiply by a scaled reciprocal.
   assign k_in     = KFull - (KWidth'(sat) * KWidth'(mul));
   assign num_in   = (NumWidth'(val_ff) * NumWidth'(k_ff)) + RoundBias;
   assign prod     = ProdWidth'(num_ff) * ProdWidth'(RecipLevel);
   assign level_in = prod[RecipShift +: ChanWidth];

   always_ff @(posedge clock) begin
      if (enable) begin
         k_ff     <= k_in;
         val_ff   <= val;
         num_ff   <= num_in;
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

endmodule

### rtl/hsv_to_rgb_convert.sv
// Converts one HSV pixel per clock to rounded 8-bit RGB. A word enters on
// every cycle in which the output stage is empty or its word is being taken,
// and its result comes out through six register stages: hue
// wrap, sector split, level scaling, level product, reciprocal division and
// channel routing. The three multipliers of the level path set the depth.
// A stall on the result side holds the whole pipeline in place.
module hsv_to_rgb_convert
   import hsvc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   hsvc_req_if.sink   req_chan,
   hsvc_rsp_if.source rsp_chan
);

   logic advance;

   logic                 valid1_ff, valid2_ff, valid3_ff, valid4_ff, valid5_ff, valid6_ff;
   logic [HueWidth-1:0]  hue1_ff, hue1_in;
   logic [ChanWidth-1:0] sat1_ff, val1_ff, sat2_ff, val2_ff;
   logic                 grey1_ff, grey2_ff, grey3_ff, grey4_ff, grey5_ff;
   logic [2:0]           sector2_ff, sector2_in, sector3_ff, sector4_ff, sector5_ff;
   logic [RemWidth-1:0]  rem2_ff, rem2_in, rem_t;
   logic [HueWidth-1:0]  base;
   logic [ChanWidth-1:0] val3_ff, val4_ff, val5_ff;
   logic [ChanWidth-1:0] p_level, q_level, t_level;
   logic [ChanWidth-1:0] red_ff, green_ff, blue_ff;
   logic [ChanWidth-1:0] red_in, green_in, blue_in;

   assign advance        = !valid6_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   assign hue1_in = (req_chan.hue_deg >= HueWrap) ? req_chan.hue_deg - HueWrap
                                                  : req_chan.hue_deg;

   always_comb begin
      if (hue1_ff >= 9'd300) begin
         sector2_in = SectorMagentaRed;
         base       = 9'd300;
      end else if (hue1_ff >= 9'd240) begin
         sector2_in = SectorBlueMagenta;
         base       = 9'd240;
      end else if (hue1_ff >= 9'd180) begin
         sector2_in = SectorCyanBlue;
         base       = 9'd180;
      end else if (hue1_ff >= 9'd120) begin
         sector2_in = SectorGreenCyan;
         base       = 9'd120;
      end else if (hue1_ff >= 9'd60) begin
         sector2_in = SectorYellowGreen;
         base       = 9'd60;
      end else begin
         sector2_in = SectorRedYellow;
         base       = 9'd0;
      end
      rem2_in = RemWidth'(hue1_ff - base);
   end

   assign rem_t = SectorSpan - rem2_ff;

   hsvc_level u_level_p (
      .clock  (clock),
      .enable (advance),
      .sat    (sat2_ff),
      .val    (val2_ff),
      .mul    (SectorSpan),
      .level  (p_level)
   );

   hsvc_level u_level_q (
      .clock  (clock),
      .enable (advance),
      .sat    (sat2_ff),
      .val    (val2_ff),
      .mul    (rem2_ff),
      .level  (q_level)
   );

   hsvc_level u_level_t (
      .clock  (clock),
      .enable (advance),
      .sat    (sat2_ff),
      .val    (val2_ff),
      .mul    (rem_t),
      .level  (t_level)
   );

   always_comb begin
      case (sector5_ff)
         SectorRedYellow: begin
            red_in = val5_ff; green_in = t_level; blue_in = p_level;
         end
         SectorYellowGreen: begin
            red_in = q_level; green_in = val5_ff; blue_in = p_level;
         end
         SectorGreenCyan: begin
            red_in = p_level; green_in = val5_ff; blue_in = t_level;
         end
         SectorCyanBlue: begin
            red_in = p_level; green_in = q_level; blue_in = val5_ff;
         end
         SectorBlueMagenta: begin
            red_in = t_level; green_in = p_level; blue_in = val5_ff;
         end
         default: begin
            red_in = val5_ff; green_in = p_level; blue_in = q_level;
         end
      endcase
      if (grey5_ff) begin
         red_in   = val5_ff;
         green_in = val5_ff;
         blue_in  = val5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
         valid6_ff <= 1'b0;
      end else if (advance) begin
         valid1_ff <= req_chan.valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
         valid4_ff <= valid3_ff;
         valid5_ff <= valid4_ff;
         valid6_ff <= valid5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hue1_ff    <= hue1_in;
         sat1_ff    <= req_chan.sat;
         val1_ff    <= req_chan.val;
         grey1_ff   <= req_chan.sat <= GreyLimit;
         sector2_ff <= sector2_in;
         rem2_ff    <= rem2_in;
         sat2_ff    <= sat1_ff;
         val2_ff    <= val1_ff;
         grey2_ff   <= grey1_ff;
         sector3_ff <= sector2_ff;
         val3_ff    <= val2_ff;
         grey3_ff   <= grey2_ff;
         sector4_ff <= sector3_ff;
         val4_ff    <= val3_ff;
         grey4_ff   <= grey3_ff;
         sector5_ff <= sector4_ff;
         val5_ff    <= val4_ff;
         grey5_ff   <= grey4_ff;
         red_ff     <= red_in;
         green_ff   <= green_in;
         blue_ff    <= blue_in;
      end
   end

   assign rsp_chan.valid = valid6_ff;
   assign rsp_chan.red   = red_ff;
   assign rsp_chan.green = green_ff;
   assign rsp_chan.blue  = blue_ff;

endmodule

### dv/hsv_to_rgb_checker.sv
`timescale 1ns / 100ps

module hsv_to_rgb_checker
   import hsvc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   hsvc_req_if        req_mon,
   hsvc_rsp_if        rsp_mon,
   output int         pending_words,
   output int         fail_count
);

   typedef struct packed {
      logic [ChanWidth-1:0] red;
      logic [ChanWidth-1:0] green;
      logic [ChanWidth-1:0] blue;
   } rgb_type;

   rgb_type expected_rgb[$];

   // Rounds val * k / FullScaleDen to the nearest integer, with halves going up.
   function automatic logic [ChanWidth-1:0] scale_level(int unsigned v, int unsigned k);
      int unsigned num;
      num = 2 * v * k + FullScaleDen;
      return ChanWidth'(num / (2 * FullScaleDen));
   endfunction

   function automatic rgb_type convert_hsv(logic [HueWidth-1:0] hue, logic [ChanWidth-1:0] sat,
                                           logic [ChanWidth-1:0] val);
      int unsigned h;
      int unsigned s;
      int unsigned span;
      int unsigned rem;
      logic [2:0] sector;
      logic [ChanWidth-1:0] lvl_p;
      logic [ChanWidth-1:0] lvl_q;
      logic [ChanWidth-1:0] lvl_t;
      rgb_type px;
      if (sat <= GreyLimit) begin
         px.red = val;
         px.green = val;
         px.blue = val;
         return px;
      end
      h = 32'(hue);
      s = 32'(sat);
      span = 32'(SectorSpan);
      if (h >= 32'(HueWrap)) begin
         h = h - 32'(HueWrap);
      end
      sector = 3'(h / span);
      rem = h % span;
      lvl_p = scale_level(32'(val), FullScaleDen - s * span);
      lvl_q = scale_level(32'(val), FullScaleDen - s * rem);
      lvl_t = scale_level(32'(val), FullScaleDen - s * (span - rem));
      case (sector)
         SectorRedYellow: begin
            px = '{val, lvl_t, lvl_p};
         end
         SectorYellowGreen: begin
            px = '{lvl_q, val, lvl_p};
         end
         SectorGreenCyan: begin
            px = '{lvl_p, val, lvl_t};
         end
         SectorCyanBlue: begin
            px = '{lvl_p, lvl_q, val};
         end
         SectorBlueMagenta: begin
            px = '{lvl_t, lvl_p, val};
         end
         default: begin
            px = '{val, lvl_p, lvl_q};
         end
      endcase
      return px;
   endfunction

   initial begin
      pending_words = 0;
      fail_count = 0;
   end

   always @(posedge clock) begin
      rgb_type want;
      rgb_type got;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready) begin
            expected_rgb.push_back(convert_hsv(req_mon.hue_deg, req_mon.sat, req_mon.val));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.red, rsp_mon.green, rsp_mon.blue};
            if (expected_rgb.size() == 0) begin
               fail_count = fail_count + 1;
               if (fail_count <= 10) begin
                  $display("Result word r=%0d g=%0d b=%0d arrived with none expected.",
                           got.red, got.green, got.blue);
               end
            end else begin
               want = expected_rgb.pop_front();
               if (got.red !== want.red || got.green !== want.green
                   || got.blue !== want.blue) begin
                  fail_count = fail_count + 1;
                  if (fail_count <= 10) begin
                     $display("Mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d.",
                              want.red, want.green, want.blue,
                              got.red, got.green, got.blue);
                  end
               end
            end
         end
         pending_words <= expected_rgb.size();
      end
   end

endmodule

### dv/tb_hsv_to_rgb_convert.sv
`timescale 1ns / 100ps

module tb_hsv_to_rgb_convert;
   import hsvc_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int PhaseWords = 225;

   logic clock;
   logic reset;
   int   idle_pct;
   int   stall_pct;
   int   cycle_count;
   int   pending_words;
   int   fail_count;

   hsvc_req_if req_chan ();
   hsvc_rsp_if rsp_chan ();

   hsv_to_rgb_convert u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   hsv_to_rgb_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .pending_words (pending_words),
      .fail_count    (fail_count)
   );

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      idle_pct = 0;
      stall_pct = 0;
      cycle_count = 0;
      req_chan.valid = 1'b0;
      req_chan.hue_deg = '0;
      req_chan.sat = '0;
      req_chan.val = '0;
      rsp_chan.ready = 1'b0;
   end

   always #4 clock = ~clock;

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("hsv_to_rgb_convert verification failed");
         $finish;
      end
   end

   task automatic send_pixel(logic [HueWidth-1:0] hue, logic [ChanWidth-1:0] sat,
                             logic [ChanWidth-1:0] val);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.hue_deg <= hue;
      req_chan.sat <= sat;
      req_chan.val <= val;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic send_random_pixel();
      logic [HueWidth-1:0]  hue;
      logic [ChanWidth-1:0] sat;
      logic [ChanWidth-1:0] val;
      hue = HueWidth'($urandom_range(0, 511));
      case ($urandom_range(0, 9))
         0: sat = ChanWidth'($urandom_range(0, 3));
         1: sat = 8'd255;
         default: sat = ChanWidth'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 9))
         0: val = 8'd0;
         1: val = 8'd255;
         default: val = ChanWidth'($urandom_range(0, 255));
      endcase
      send_pixel(hue, sat, val);
   endtask

   initial begin
      int phase_idle[4];
      int phase_stall[4];
      int hue_edges[15];
      phase_idle = '{0, 58, 0, 21};
      phase_stall = '{0, 0, 58, 21};
      hue_edges = '{0, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300, 359, 360, 419, 511};
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Sector boundaries and hue wrap at full saturation and value.
      foreach (hue_edges[i]) begin
         send_pixel(HueWidth'(hue_edges[i]), 8'd255, 8'd255);
      end
      // Grey threshold on both sides.
      send_pixel(9'd100, 8'd0, 8'd200);
      send_pixel(9'd100, 8'd1, 8'd200);
      send_pixel(9'd100, 8'd2, 8'd200);
      send_pixel(9'd100, 8'd3, 8'd200);
      send_pixel(9'd511, 8'd3, 8'd1);
      send_pixel(9'd200, 8'd255, 8'd0);
      send_pixel(9'd45, 8'd255, 8'd128);
      // Exact halves that must round up.
      send_pixel(9'd30, 8'd255, 8'd1);
      send_pixel(9'd90, 8'd255, 8'd1);

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = phase_idle[phase];
         stall_pct = phase_stall[phase];
         for (int n = 0; n < PhaseWords; n++) begin
            if (phase == 1 && n == 100) begin
               req_chan.valid <= 1'b0;
               wait (pending_words == 0);
               @(negedge clock);
            end
            send_random_pixel();
         end
      end
      req_chan.valid <= 1'b0;
      stall_pct = 0;

      wait (pending_words == 0);
      repeat (16) @(posedge clock);
      if (fail_count == 0) begin
         $display("hsv_to_rgb_convert verification clean");
      end else begin
         $display("hsv_to_rgb_convert verification failed");
      end
      $finish;
   end

endmodule

### files.f
rtl/hsvc_pkg.sv
rtl/hsvc_req_if.sv
rtl/hsvc_rsp_if.sv
rtl/hsvc_level.sv
rtl/hsv_to_rgb_convert.sv
dv/hsv_to_rgb_checker.sv
dv/tb_hsv_to_rgb_convert.sv
